>>> src/cipid_pkg.sv
// Shared widths, register indexes and reset values for the incremental PID block.
`timescale 1ns / 1ps
package cipid_pkg;

  // Sample and gain formats
  localparam int DATA_WIDTH     = 24;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int GAIN_W         = 16;
  localparam int LIMIT_W        = 15;
  localparam int OUT_W          = 16;
  localparam int CFG_IDX_W      = 2;

  // Datapath widths: error, first and second difference, products, sum
  localparam int ERR_W   = DATA_WIDTH + 1;
  localparam int D1_W    = ERR_W + 1;
  localparam int D2_W    = ERR_W + 2;
  localparam int PROD_W  = D2_W + GAIN_W + 1;
  localparam int ACC_W   = PROD_W + 2;
  localparam int WHOLE_W = ACC_W - GAIN_FRAC_BITS;

  // Register reset values
  localparam logic [GAIN_W-1:0]  GAIN_PROP_RST    = 16'd512;
  localparam logic [GAIN_W-1:0]  GAIN_INTEG_RST   = 16'd358;
  localparam logic [GAIN_W-1:0]  GAIN_DERIV_RST   = 16'd205;
  localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RST = 15'd30;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_PROP    = 2'd0,
    REG_GAIN_INTEG   = 2'd1,
    REG_GAIN_DERIV   = 2'd2,
    REG_OUTPUT_LIMIT = 2'd3
  } reg_index_t;

endpackage

>>> src/clamped_incremental_pid.sv
// Top level: velocity-form PID step with Q8.8 gains and a symmetric output clamp.
`timescale 1ns / 1ps
// Takes one word per clock while not stalled. The error (setpoint - measured)
// is formed as the word is accepted and held in an input register; as the word
// leaves that register, the three gain products, their sum, the truncation
// toward zero and the clamp to +/- output_limit are computed in one pass into
// the result register, and the error history shifts at that same edge. While
// results are drained, the input register passes each word on as it takes
// the next, so a new word is taken every cycle; the result register decouples
// the two sides, so input stalls only when both the input and result registers
// are full and the result word is not taken in that cycle. drive_step is the
// increment itself, not an accumulated output. Gains and limit are written
// through the plain write port and must only change while the block is idle.
module clamped_incremental_pid (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration write port
  input  logic                                   cfg_we,
  input  logic [cipid_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cipid_pkg::GAIN_W-1:0]           cfg_data,
  // input words
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [cipid_pkg::DATA_WIDTH-1:0] measured,
  input  logic signed [cipid_pkg::DATA_WIDTH-1:0] setpoint,
  // result words
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [cipid_pkg::OUT_W-1:0]     drive_step
);

  // Configuration registers
  logic [cipid_pkg::GAIN_W-1:0]  gain_prop;
  logic [cipid_pkg::GAIN_W-1:0]  gain_integ;
  logic [cipid_pkg::GAIN_W-1:0]  gain_deriv;
  logic [cipid_pkg::LIMIT_W-1:0] output_limit;

  // Pipeline and history
  logic                                  s1_valid;
  logic signed [cipid_pkg::ERR_W-1:0]    s1_err;
  logic signed [cipid_pkg::ERR_W-1:0]    err_next;
  logic signed [cipid_pkg::ERR_W-1:0]    prev_error;
  logic signed [cipid_pkg::ERR_W-1:0]    prev_prev_error;
  logic                                  advance;

  // Datapath
  logic signed [cipid_pkg::D1_W-1:0]     d1;
  logic signed [cipid_pkg::D2_W-1:0]     d2;
  logic signed [cipid_pkg::PROD_W-1:0]   prod_p;
  logic signed [cipid_pkg::PROD_W-1:0]   prod_i;
  logic signed [cipid_pkg::PROD_W-1:0]   prod_d;
  logic signed [cipid_pkg::ACC_W-1:0]    acc;
  logic signed [cipid_pkg::ACC_W-1:0]    acc_biased;
  logic signed [cipid_pkg::WHOLE_W-1:0]  whole;
  logic signed [cipid_pkg::WHOLE_W-1:0]  lim_pos;
  logic signed [cipid_pkg::WHOLE_W-1:0]  lim_neg;
  logic signed [cipid_pkg::WHOLE_W-1:0]  clamped;
  logic signed [cipid_pkg::OUT_W-1:0]    drive_next;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop    <= cipid_pkg::GAIN_PROP_RST;
      gain_integ   <= cipid_pkg::GAIN_INTEG_RST;
      gain_deriv   <= cipid_pkg::GAIN_DERIV_RST;
      output_limit <= cipid_pkg::OUTPUT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cipid_pkg::reg_index_t'(cfg_index))
        cipid_pkg::REG_GAIN_PROP:    gain_prop    <= cfg_data;
        cipid_pkg::REG_GAIN_INTEG:   gain_integ   <= cfg_data;
        cipid_pkg::REG_GAIN_DERIV:   gain_deriv   <= cfg_data;
        cipid_pkg::REG_OUTPUT_LIMIT: output_limit <= cfg_data[cipid_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on when the result register frees up
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Error formed at acceptance, full precision
  assign err_next = cipid_pkg::ERR_W'(setpoint) - cipid_pkg::ERR_W'(measured);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_err <= err_next;
    end
  end

  // Differences against the history
  assign d1 = cipid_pkg::D1_W'(s1_err) - cipid_pkg::D1_W'(prev_error);
  assign d2 = cipid_pkg::D2_W'(s1_err) - (cipid_pkg::D2_W'(prev_error) <<< 1)
            + cipid_pkg::D2_W'(prev_prev_error);

  // Gain products (gains are unsigned, widened with a zero sign bit)
  assign prod_p = cipid_pkg::PROD_W'($signed({1'b0, gain_prop}))  * cipid_pkg::PROD_W'(d1);
  assign prod_i = cipid_pkg::PROD_W'($signed({1'b0, gain_integ})) * cipid_pkg::PROD_W'(s1_err);
  assign prod_d = cipid_pkg::PROD_W'($signed({1'b0, gain_deriv})) * cipid_pkg::PROD_W'(d2);

  // Sum, then drop the fraction bits rounding toward zero
  assign acc = cipid_pkg::ACC_W'(prod_p) + cipid_pkg::ACC_W'(prod_i)
             + cipid_pkg::ACC_W'(prod_d);
  assign acc_biased = acc[cipid_pkg::ACC_W-1]
                    ? acc + cipid_pkg::ACC_W'((1 << cipid_pkg::GAIN_FRAC_BITS) - 1)
                    : acc;
  assign whole = cipid_pkg::WHOLE_W'(acc_biased >>> cipid_pkg::GAIN_FRAC_BITS);

  // Symmetric clamp
  assign lim_pos = $signed(cipid_pkg::WHOLE_W'(output_limit));
  assign lim_neg = -lim_pos;

  always_comb begin
    priority if (whole > lim_pos) begin
      clamped = lim_pos;
    end else if (whole < lim_neg) begin
      clamped = lim_neg;
    end else begin
      clamped = whole;
    end
  end

  assign drive_next = clamped[cipid_pkg::OUT_W-1:0];

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive_step <= drive_next;
    end
  end

  // Error history shifts as each word leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error      <= '0;
      prev_prev_error <= '0;
    end else if (advance) begin
      prev_prev_error <= prev_error;
      prev_error      <= s1_err;
    end
  end

  // History takes the error of the word just computed
  a_hist_e1: assert property (@(posedge clk) disable iff (rst)
    advance |=> prev_error == $past(s1_err))
    else $error("prev_error not loaded from computed word");

  a_hist_e2: assert property (@(posedge clk) disable iff (rst)
    advance |=> prev_prev_error == $past(prev_error))
    else $error("prev_prev_error not shifted");

  // A computed word always lands in the result register
  a_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result lost after advance");

  // History holds while no word is computed
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(prev_error) && $stable(prev_prev_error))
    else $error("history changed without a word");

endmodule
